// ===== rtl/core/rgbled_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbled_pkg - shared types and constants for the RGB LED chain encoder
// Item codes, status codes, waveform phases, register map and reset values.
// ----------------------------------------------------------------------------
package rgbled_pkg;

  typedef enum logic [1:0] {
    ACT_SCALED = 2'd0,
    ACT_RAW    = 2'd1,
    ACT_SHOW   = 2'd2,
    ACT_TICK   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_LATCH = 2'd2
  } phase_t;

  // register map
  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_CHAIN_LEN  = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd3;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd4;
  localparam logic [2:0] REG_ONE_LOW    = 3'd5;
  localparam logic [2:0] REG_LATCH      = 3'd6;

  localparam int TW = 15;  // tick duration width
  localparam int RW = 15;  // config write data width

  localparam logic [7:0]    BRIGHTNESS_RST = 8'd255;
  localparam logic [8:0]    CHAIN_LEN_RST  = 9'd1;
  localparam logic [TW-1:0] ZERO_HIGH_RST  = 15'd16;
  localparam logic [TW-1:0] ZERO_LOW_RST   = 15'd34;
  localparam logic [TW-1:0] ONE_HIGH_RST   = 15'd32;
  localparam logic [TW-1:0] ONE_LOW_RST    = 15'd18;
  localparam logic [TW-1:0] LATCH_RST      = 15'd2000;

  localparam logic [4:0] LAST_BIT = 5'd23;

  // one result item
  typedef struct packed {
    logic    line_level;
    logic    busy_res;
    logic    frame_done;
    status_t status;
  } result_t;

  // write request into the pixel store, pixel kept as {red, green, blue}
  typedef struct packed {
    logic        we;
    logic [11:0] addr;
    logic [23:0] data;
  } wr_req_t;

  // a zero duration counts as one tick
  function automatic logic [TW-1:0] min1(input logic [TW-1:0] v);
    return (v == '0) ? TW'(1) : v;
  endfunction

endpackage

// ===== rtl/core/rgb_led_chain_waveform_encoder.sv =====
// ----------------------------------------------------------------------------
// rgb_led_chain_waveform_encoder - single-wire RGB LED chain driver
// Pixel store with scaled/raw writes and a tick-driven frame waveform.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low: each write, show or tick
// transfer yields exactly one result, registered into the result buffer. A
// two-entry result buffer lets input transfers continue while a result waits;
// in_stall rises when both entries are full and while the store is cleared.
// Pixels live in a MAX_LEDS x 24 memory whose registered read port always
// points at the pixel that the next tick will send, so a tick can follow a
// show or a pixel boundary in the very next cycle. After reset the memory
// is zeroed one entry per cycle: in_stall stays high until the sweep ends,
// while configuration writes are taken as usual. Timing and count registers
// are read live on every tick: a change in mid-frame takes effect at once,
// and a count lowered below the current pixel ends the frame after that pixel.
// ----------------------------------------------------------------------------
module rgb_led_chain_waveform_encoder
  import rgbled_pkg::*;
#(
  parameter int MAX_LEDS = 256
) (
  input  logic          clk,
  input  logic          rst,
  // configuration
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [RW-1:0] wr_data,
  // item channel
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    action,
  input  logic [7:0]    index,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output logic          line_level,
  output logic          busy_res,
  output logic          frame_done,
  output logic [1:0]    status
);

  // address width of the store, count width able to hold the pixel count
  localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW0 = $clog2(MAX_LEDS + 1);
  localparam int CW  = (CW0 > 9) ? CW0 : 9;

  // configuration registers
  logic [7:0]    brightness;
  logic [8:0]    chain_len;
  logic [TW-1:0] zero_high_ticks, zero_low_ticks;
  logic [TW-1:0] one_high_ticks, one_low_ticks;
  logic [TW-1:0] latch_ticks;

  // frame state
  logic          sending, sending_next;
  logic [CW-1:0] pixel_position, pixel_position_next;
  logic [4:0]    bit_position, bit_position_next;
  phase_t        wave_phase, wave_phase_next;
  logic [TW-1:0] tick_counter, tick_counter_next;

  // result buffer
  result_t       res_buf [2];
  logic          res_wr_ptr, res_rd_ptr;
  logic [1:0]    res_count;

  logic          in_accept, res_pop;
  act_t          act;
  result_t       res;
  wr_req_t       wr_req;
  logic          clearing;
  logic [23:0]   pix_data, scaled;
  logic [23:0]   grb;
  logic          cur_bit;
  logic [CW-1:0] eff_count, idx_ext, max_c, cnt_ext;
  logic [TW:0]   cnt_inc;
  logic [TW-1:0] dur;
  logic          part_end;

  //--------------------------------------------------------------------------
  // configuration port
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= BRIGHTNESS_RST;
      chain_len       <= CHAIN_LEN_RST;
      zero_high_ticks <= ZERO_HIGH_RST;
      zero_low_ticks  <= ZERO_LOW_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      one_low_ticks   <= ONE_LOW_RST;
      latch_ticks     <= LATCH_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_BRIGHTNESS: brightness      <= wr_data[7:0];
        REG_CHAIN_LEN:  chain_len       <= wr_data[8:0];
        REG_ZERO_HIGH:  zero_high_ticks <= wr_data[TW-1:0];
        REG_ZERO_LOW:   zero_low_ticks  <= wr_data[TW-1:0];
        REG_ONE_HIGH:   one_high_ticks  <= wr_data[TW-1:0];
        REG_ONE_LOW:    one_low_ticks   <= wr_data[TW-1:0];
        REG_LATCH:      latch_ticks     <= wr_data[TW-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // handshake
  //--------------------------------------------------------------------------
  assign in_stall  = clearing || (res_count == 2'd2);
  assign in_accept = in_valid && !in_stall;
  assign act       = act_t'(action);

  // pixels sent per frame: min(chain_len, MAX_LEDS)
  assign cnt_ext   = CW'(chain_len);
  assign max_c     = CW'(MAX_LEDS);
  assign eff_count = (cnt_ext < max_c) ? cnt_ext : max_c;
  assign idx_ext   = CW'(index);

  //--------------------------------------------------------------------------
  // pixel store and scaling
  //--------------------------------------------------------------------------
  rgbled_scale u_scale (
    .brightness (brightness),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .scaled     (scaled)
  );

  // read address follows the next pixel position, so pix_data always holds
  // the pixel being sent (the store is frozen while a frame is running)
  rgbled_store #(
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_req   (wr_req),
    .rd_addr  (pixel_position_next[AW-1:0]),
    .rd_data  (pix_data),
    .clearing (clearing)
  );

  // wire order green, red, blue, MSB first
  assign grb     = {pix_data[15:8], pix_data[23:16], pix_data[7:0]};
  assign cur_bit = grb[LAST_BIT - bit_position];

  // duration of the current part of the waveform
  always_comb begin
    case (wave_phase)
      PH_HIGH:  dur = min1(cur_bit ? one_high_ticks : zero_high_ticks);
      PH_LOW:   dur = min1(cur_bit ? one_low_ticks : zero_low_ticks);
      default:  dur = min1(latch_ticks);
    endcase
  end

  assign cnt_inc  = {1'b0, tick_counter} + (TW+1)'(1);
  assign part_end = (cnt_inc >= {1'b0, dur});

  //--------------------------------------------------------------------------
  // next state
  //--------------------------------------------------------------------------
  always_comb begin
    sending_next        = sending;
    pixel_position_next = pixel_position;
    bit_position_next   = bit_position;
    wave_phase_next     = wave_phase;
    tick_counter_next   = tick_counter;
    if (in_accept && !sending) begin
      if (act == ACT_SHOW) begin
        sending_next        = 1'b1;
        pixel_position_next = '0;
        bit_position_next   = '0;
        tick_counter_next   = '0;
        wave_phase_next     = (eff_count == '0) ? PH_LATCH : PH_HIGH;
      end
    end else if (in_accept && act == ACT_TICK) begin
      if (!part_end) begin
        tick_counter_next = cnt_inc[TW-1:0];
      end else begin
        tick_counter_next = '0;
        case (wave_phase)
          PH_HIGH: begin
            wave_phase_next = PH_LOW;
          end
          PH_LOW: begin
            wave_phase_next = PH_HIGH;
            if (bit_position == LAST_BIT) begin
              bit_position_next   = '0;
              pixel_position_next = pixel_position + CW'(1);
              // a lowered count ends the frame after the current pixel
              if (pixel_position + CW'(1) >= eff_count) begin
                wave_phase_next = PH_LATCH;
              end
            end else begin
              bit_position_next = bit_position + 5'd1;
            end
          end
          PH_LATCH: begin
            sending_next        = 1'b0;
            pixel_position_next = '0;
            bit_position_next   = '0;
            wave_phase_next     = PH_HIGH;
          end
          default: ;
        endcase
      end
    end
  end

  //--------------------------------------------------------------------------
  // result and store write
  //--------------------------------------------------------------------------
  always_comb begin
    res          = '0;
    res.status   = ST_OK;
    res.busy_res = sending;
    wr_req       = '0;
    case (act)
      ACT_SCALED, ACT_RAW: begin
        if (sending) begin
          res.status = ST_BUSY;
        end else if (idx_ext >= eff_count) begin
          res.status = ST_RANGE;
        end else begin
          wr_req.we   = in_accept;
          wr_req.addr = 12'(index);
          wr_req.data = (act == ACT_SCALED) ? scaled : {red, green, blue};
        end
      end
      ACT_SHOW: begin
        if (sending) begin
          res.status = ST_BUSY;
        end
        res.busy_res = 1'b1;
      end
      ACT_TICK: begin
        if (sending) begin
          res.line_level = (wave_phase == PH_HIGH);
          res.frame_done = (wave_phase == PH_LATCH) && part_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending        <= 1'b0;
      pixel_position <= '0;
      bit_position   <= '0;
      wave_phase     <= PH_HIGH;
      tick_counter   <= '0;
    end else begin
      sending        <= sending_next;
      pixel_position <= pixel_position_next;
      bit_position   <= bit_position_next;
      wave_phase     <= wave_phase_next;
      tick_counter   <= tick_counter_next;
    end
  end

  //--------------------------------------------------------------------------
  // two-entry result buffer
  //--------------------------------------------------------------------------
  assign res_pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (in_accept) begin
        res_wr_ptr <= !res_wr_ptr;
      end
      if (res_pop) begin
        res_rd_ptr <= !res_rd_ptr;
      end
      case ({in_accept, res_pop})
        2'b10:   res_count <= res_count + 2'd1;
        2'b01:   res_count <= res_count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_buf[res_wr_ptr] <= res;
    end
  end

  assign out_valid  = (res_count != 2'd0);
  assign line_level = res_buf[res_rd_ptr].line_level;
  assign busy_res   = res_buf[res_rd_ptr].busy_res;
  assign frame_done = res_buf[res_rd_ptr].frame_done;
  assign status     = res_buf[res_rd_ptr].status;

`ifndef SYNTH
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("item accepted during store clear");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (pixel_position == '0 && bit_position == '0 && tick_counter == '0))
    else $error("frame state not cleared while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_position <= LAST_BIT)
    else $error("bit position past end of pixel");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res.frame_done) |=> !sending)
    else $error("frame still running after done");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= 2'd2)
    else $error("result buffer overflow");
`endif

endmodule

// ===== rtl/core/rgbled_scale.sv =====
// ----------------------------------------------------------------------------
// rgbled_scale - brightness scaling of one pixel
// Each channel becomes (value * brightness) / 255, floor.
// ----------------------------------------------------------------------------
module rgbled_scale
  import rgbled_pkg::*;
(
  input  logic [7:0]  brightness,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic [23:0] scaled
);

  // floor(x / 255) for x < 65280: (x + 1 + (x >> 8)) >> 8
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

  logic [15:0] prod_r, prod_g, prod_b;

  assign prod_r = red   * brightness;
  assign prod_g = green * brightness;
  assign prod_b = blue  * brightness;

  assign scaled = {div255(prod_r), div255(prod_g), div255(prod_b)};

endmodule

// ===== rtl/core/rgbled_store.sv =====
// ----------------------------------------------------------------------------
// rgbled_store - pixel store memory
// One write port, one registered read port, zero sweep after reset.
// ----------------------------------------------------------------------------
module rgbled_store
  import rgbled_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  wr_req_t       wr_req,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data,
  output logic          clearing
);

  logic [23:0]   mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_req.we) begin
      mem[wr_req.addr[AW-1:0]] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
